>>> sv/abas_pkg.sv
// abas_pkg: shared constants, codes and types for the ADC block averager.
// Used by abas_divider, abas_multiplier and adc_block_average_stats.
`default_nettype none

package abas_pkg;

  // Fixed sizing of the block
  localparam int SAMPLE_BITS       = 12;
  localparam int MAX_AVERAGE       = 100;
  localparam int MAX_BLOCK         = 1024;
  localparam int CHANNEL_COUNT     = 16;
  localparam int MIN_US_PER_SAMPLE = 2;

  // Register widths
  localparam int AVG_W      = 7;
  localparam int BLK_W      = 11;
  localparam int INTERVAL_W = 16;
  localparam int CHAN_W     = 4;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 2;

  // Datapath widths
  localparam int ACC_W  = $clog2(MAX_AVERAGE * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int MEAN_W = ACC_W;   // a mean can exceed the sample range after a count change
  localparam int SUM_W  = $clog2(MAX_BLOCK * ((1 << MEAN_W) - 1) + 1);
  localparam int SQ_W   = 34;      // square sum is kept modulo 2^SQ_W
  localparam int OUT_W  = 12;
  localparam int STAT_W = 2;
  localparam int DIV_W  = SUM_W;
  localparam int DEN_W  = BLK_W;
  localparam int MUL_W  = MEAN_W;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_AVERAGE_COUNT     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_COUNT       = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLING_INTERVAL = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_INDEX     = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_UNSUPPORTED = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_BAD_CHANNEL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_SQ_MEAN,
    ST_DIV_AVG,
    ST_MUL_NA,
    ST_MUL_SQ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [OUT_W-1:0]  average_value;
    logic [OUT_W-1:0]  block_min;
    logic [OUT_W-1:0]  block_max;
    logic [SQ_W-1:0]   square_sum;
    logic [STAT_W-1:0] status;
    logic              last_of_block;
  } result_t;

endpackage

`default_nettype wire

>>> sv/abas_divider.sv
// abas_divider: restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on abas_pkg for widths.
`default_nettype none

module abas_divider
  import abas_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;

  // dividend bits shift out of the top of quo while quotient bits shift in
  assign rem_sh  = {rem, quo[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign fits    = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        den  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[DIV_W-2:0], fits};
        rem <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

>>> sv/abas_multiplier.sv
// abas_multiplier: bit-serial shift-add multiply-accumulate, modulo 2^SQ_W.
// Depends on abas_pkg for widths.
`default_nettype none

module abas_multiplier
  import abas_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SQ_W-1:0]  init,
  input  logic [SQ_W-1:0]  mcand,
  input  logic [MUL_W-1:0] mplier,
  output logic             done,
  output logic [SQ_W-1:0]  product
);

  localparam int CNT_W = $clog2(MUL_W);

  logic [SQ_W-1:0]  prod;
  logic [SQ_W-1:0]  a;
  logic [MUL_W-1:0] b;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        prod <= init;
        a    <= mcand;
        b    <= mplier;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (b[0]) begin
          prod <= prod + a;
        end
        a   <= {a[SQ_W-2:0], 1'b0};
        b   <= {1'b0, b[MUL_W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = prod;

endmodule

`default_nettype wire

>>> sv/adc_block_average_stats.sv
// adc_block_average_stats: oversampling averager with block min, max and square sum.
// Depends on abas_pkg, abas_divider and abas_multiplier.
//
// Raw samples enter on s_axis; each request adds one sample to the running sum.
// Every average_count samples one result leaves on m_axis with the truncated
// mean and the block's min and max so far; the last mean of a block (tlast)
// also carries the sum of squared deviations from the floored block mean.
// With an invalid setup (interval below twice the count, or count over 100)
// each request gives one result with status "unsupported" and changes nothing.
// Flow: a sample that completes no mean is taken and the block stays idle. A
// mean runs through the serial divider (29 steps) and the serial squarer (19
// steps) before its result is emitted. The end of a block adds one more divide
// and two multiplies. An unsupported setup goes from idle straight to the emit
// state. s_axis_tready comes back in the cycle the result is loaded; one sample
// is in work at a time.
// The result sits in an output register, so the next sample is taken while
// the receiver stalls; work only waits if a second result is ready.
// Reset (rst, synchronous) restores the register defaults and clears all sums.
// Configuration writes are taken any cycle, but are meant for idle periods.
`default_nettype none

module adc_block_average_stats
  import abas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  // samples
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [11:0] raw_sample
  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [71:0]           m_axis_tdata,   // average_value, block_min, block_max,
                                                // square_sum, zero fill
  output logic [STAT_W-1:0]     m_axis_tuser,   // status
  output logic                  m_axis_tlast    // last_of_block
);

  state_t state, state_next;

  logic [AVG_W-1:0]      avg_count;
  logic [BLK_W-1:0]      blk_count;
  logic [INTERVAL_W-1:0] interval;
  logic [CHAN_W-1:0]     chan;

  logic [ACC_W-1:0]  acc;
  logic [AVG_W-1:0]  raw_cnt;
  logic [BLK_W-1:0]  blk_pos;
  logic [MEAN_W-1:0] run_min;
  logic [MEAN_W-1:0] run_max;
  logic [SUM_W-1:0]  sum_s;
  logic [SQ_W-1:0]   sum_q;
  logic [MEAN_W-1:0] mean;
  logic [MEAN_W-1:0] floor_mean;
  logic              is_last;
  result_t           res;
  result_t           out_res;

  logic [AVG_W-1:0]   n_avg;
  logic [BLK_W-1:0]   n_blk;
  logic               cfg_ok;
  logic               in_fire;
  logic [ACC_W-1:0]   acc_sum;
  logic [AVG_W-1:0]   cnt_inc;
  logic               mean_done;
  logic [MEAN_W-1:0]  mean_new;
  logic [BLK_W-1:0]   pos_inc;
  logic [MEAN_W-1:0]  min_new;
  logic [MEAN_W-1:0]  max_new;
  logic [STAT_W-1:0]  status_now;
  logic               out_free;

  logic             div_start;
  logic [DIV_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;

  logic             mul_start;
  logic [SQ_W-1:0]  mul_init;
  logic [SQ_W-1:0]  mul_a;
  logic [MUL_W-1:0] mul_b;
  logic             mul_done;
  logic [SQ_W-1:0]  mul_prod;

  abas_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quot)
  );

  abas_multiplier u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .init    (mul_init),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  // effective counts and setup check
  assign n_avg  = (avg_count == '0) ? AVG_W'(1) : avg_count;
  assign n_blk  = (blk_count == '0) ? BLK_W'(1) :
                  (blk_count > BLK_W'(MAX_BLOCK)) ? BLK_W'(MAX_BLOCK) : blk_count;
  assign cfg_ok = ((INTERVAL_W+1)'(interval) >=
                   (INTERVAL_W+1)'(avg_count) * (INTERVAL_W+1)'(MIN_US_PER_SAMPLE)) &&
                  (avg_count <= AVG_W'(MAX_AVERAGE));

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign acc_sum       = acc + ACC_W'(s_axis_tdata[SAMPLE_BITS-1:0]);
  assign cnt_inc       = raw_cnt + 1'b1;
  assign mean_done     = cnt_inc >= n_avg;

  assign mean_new   = div_quot[MEAN_W-1:0];
  assign pos_inc    = blk_pos + 1'b1;
  assign min_new    = (blk_pos == '0 || mean_new < run_min) ? mean_new : run_min;
  assign max_new    = (blk_pos == '0 || mean_new > run_max) ? mean_new : run_max;
  assign status_now = ({1'b0, chan} >= (CHAN_W+1)'(CHANNEL_COUNT)) ?
                      STATUS_BAD_CHANNEL : STATUS_OK;
  assign out_free   = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: mean divide, square, then at block end floor-mean divide and
  // the two multiplies of Q + a * (n * a - 2 * S)
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    mul_start  = 1'b0;
    mul_init   = '0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (!cfg_ok) begin
            state_next = ST_EMIT;
          end else if (mean_done) begin
            div_start  = 1'b1;
            div_num    = DIV_W'(acc_sum);
            div_den    = DEN_W'(n_avg);
            state_next = ST_DIV_MEAN;
          end
        end
      end
      ST_DIV_MEAN: begin
        if (div_done) begin
          mul_start  = 1'b1;
          mul_init   = sum_q;
          mul_a      = SQ_W'(mean_new);
          mul_b      = mean_new;
          state_next = ST_SQ_MEAN;
        end
      end
      ST_SQ_MEAN: begin
        if (mul_done) begin
          if (is_last) begin
            div_start  = 1'b1;
            div_num    = DIV_W'(sum_s);
            div_den    = blk_pos;
            state_next = ST_DIV_AVG;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_DIV_AVG: begin
        if (div_done) begin
          mul_start  = 1'b1;
          mul_a      = SQ_W'(blk_pos);
          mul_b      = mean_new;
          state_next = ST_MUL_NA;
        end
      end
      ST_MUL_NA: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_init   = sum_q;
          mul_a      = mul_prod - SQ_W'({sum_s, 1'b0});
          mul_b      = floor_mean;
          state_next = ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: begin
        if (mul_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_count     <= AVG_W'(1);
      blk_count     <= BLK_W'(1);
      interval      <= INTERVAL_W'(2);
      chan          <= '0;
      acc           <= '0;
      raw_cnt       <= '0;
      blk_pos       <= '0;
      run_min       <= '0;
      run_max       <= '0;
      sum_s         <= '0;
      sum_q         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_addr)
          REG_AVERAGE_COUNT:     avg_count <= cfg_wdata[AVG_W-1:0];
          REG_BLOCK_COUNT:       blk_count <= cfg_wdata[BLK_W-1:0];
          REG_SAMPLING_INTERVAL: interval  <= cfg_wdata[INTERVAL_W-1:0];
          REG_CHANNEL_INDEX:     chan      <= cfg_wdata[CHAN_W-1:0];
          default: ;
        endcase
      end

      // a new result may be loaded in the cycle the old one is taken
      if (state == ST_EMIT && out_free) begin
        out_res       <= res;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (!cfg_ok) begin
              res <= '{average_value: '0, block_min: '0, block_max: '0,
                       square_sum: '0, status: STATUS_UNSUPPORTED,
                       last_of_block: 1'b0};
            end else if (mean_done) begin
              acc     <= '0;
              raw_cnt <= '0;
            end else begin
              acc     <= acc_sum;
              raw_cnt <= cnt_inc;
            end
          end
        end
        ST_DIV_MEAN: begin
          if (div_done) begin
            mean    <= mean_new;
            run_min <= min_new;
            run_max <= max_new;
            sum_s   <= sum_s + SUM_W'(mean_new);
            blk_pos <= pos_inc;
            is_last <= pos_inc >= n_blk;
          end
        end
        ST_SQ_MEAN: begin
          if (mul_done) begin
            sum_q <= mul_prod;
            if (!is_last) begin
              res <= '{average_value: mean[OUT_W-1:0],
                       block_min: run_min[OUT_W-1:0],
                       block_max: run_max[OUT_W-1:0],
                       square_sum: '0, status: status_now,
                       last_of_block: 1'b0};
            end
          end
        end
        ST_DIV_AVG: begin
          if (div_done) begin
            floor_mean <= mean_new;
          end
        end
        ST_MUL_SQ: begin
          if (mul_done) begin
            res <= '{average_value: mean[OUT_W-1:0],
                     block_min: run_min[OUT_W-1:0],
                     block_max: run_max[OUT_W-1:0],
                     square_sum: mul_prod, status: status_now,
                     last_of_block: 1'b1};
            blk_pos <= '0;
            run_min <= '0;
            run_max <= '0;
            sum_s   <= '0;
            sum_q   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {2'b00, out_res.square_sum, out_res.block_max,
                         out_res.block_min, out_res.average_value};
  assign m_axis_tuser = out_res.status;
  assign m_axis_tlast = out_res.last_of_block;

endmodule

`default_nettype wire
